// ===== src/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, codes and helpers of the infix to postfix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

    // default sizes
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_QUEUE_DEPTH = 4;

    // field widths
    localparam int KIND_W  = 3;
    localparam int VALUE_W = 4;
    localparam int OKIND_W = 2;
    localparam int ERR_W   = 2;
    localparam int ENTRY_W = 3;
    localparam int PEND_W  = 5;

    // stack entry code for a left parenthesis
    localparam logic [ENTRY_W-1:0] PAREN_MARK = 3'd4;
    // highest valid operator code
    localparam logic [VALUE_W-1:0] OP_MAX = 4'd3;
    // saturation value of the operand counter
    localparam logic [PEND_W-1:0] PENDING_MAX = 5'd31;

    // input token kinds
    typedef enum logic [KIND_W-1:0] {
        TK_DIGIT  = 3'd0,
        TK_OP     = 3'd1,
        TK_LPAREN = 3'd2,
        TK_RPAREN = 3'd3,
        TK_END    = 3'd4
    } t_tok_kind;

    // result kinds
    typedef enum logic [OKIND_W-1:0] {
        OK_OPERAND  = 2'd0,
        OK_OPERATOR = 2'd1,
        OK_END      = 2'd2
    } t_out_kind;

    // error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_OPERAND  = 2'd2,
        ERR_PAREN    = 2'd3
    } t_err;

    // classified token between front and back
    typedef struct packed {
        t_tok_kind          kind;
        logic [VALUE_W-1:0] value;
    } t_token;

    // one result item
    typedef struct packed {
        t_out_kind          kind;
        logic [VALUE_W-1:0] value;
        logic               last;
        t_err               err;
    } t_result;

    // operator priority: plus and minus 1, times and divide 2, else 0
    function automatic logic [1:0] priority_of(input logic [ENTRY_W-1:0] code);
        logic [1:0] p;
        if (code < 3'd2) begin
            p = 2'd1;
        end else if (code < 3'd4) begin
            p = 2'd2;
        end else begin
            p = 2'd0;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== src/infix_to_postfix_converter.sv =====
// A token passes the classifier stage, the queue and the stack engine steps
// (accept, top read of the stack memory, decide); results go through the hold
// and output stages, and each operator popped from the stack repeats the top
// read and decide. The stack engine takes a new token only once it is through
// with the last one. Reset: i_rst_n is synchronous, active low; it empties
// queue and stack and clears the operand count. Stack memory is not cleared.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter from tokenized infix to postfix order.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [7:0]        i_s_tdata,   // [3:0] token_value, [7:4] zero
    input  wire logic [KIND_W-1:0] i_s_tuser,   // [2:0] token_kind
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [7:0]             o_m_tdata,   // [3:0] out_value, [5:4] error
    output logic [OKIND_W-1:0]     o_m_tuser,   // [1:0] out_kind
    output logic                   o_m_tlast
);

    logic    w_f_valid, w_f_ready;
    t_token  w_f_tok;
    logic    w_q_valid, w_q_ready;
    t_token  w_q_tok;
    t_result w_res;

    // classifier
    itp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (i_s_tvalid),
        .o_tready    (o_s_tready),
        .i_kind      (i_s_tuser),
        .i_value     (i_s_tdata[VALUE_W-1:0]),
        .o_tok_valid (w_f_valid),
        .o_tok       (w_f_tok),
        .i_tok_ready (w_f_ready)
    );

    // token queue
    itp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_tok   (w_f_tok),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_tok   (w_q_tok)
    );

    // stack engine
    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_q_valid),
        .o_tok_ready (w_q_ready),
        .i_tok       (w_q_tok),
        .o_res_valid (o_m_tvalid),
        .o_res       (w_res),
        .i_res_ready (i_m_tready)
    );

    // result packing
    assign o_m_tdata = {2'b00, w_res.err, w_res.value};
    assign o_m_tuser = w_res.kind;
    assign o_m_tlast = w_res.last;

endmodule

`default_nettype wire

// ===== src/itp_front.sv =====
// ----------------------------------------------------------------------------
// itp_front
// Accepts raw tokens, drops ignored kinds and bad operator codes, and hands
// classified tokens to the queue through a registered stage.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_front
    import itp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_tvalid,
    output logic                    o_tready,
    input  wire logic [KIND_W-1:0]  i_kind,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_tok_valid,
    output t_token                  o_tok,
    input  wire logic               i_tok_ready
);

    logic   r_valid;
    t_token r_tok;
    logic   w_keep;
    t_token w_tok;

    // classify the incoming token
    always_comb begin
        w_keep      = 1'b0;
        w_tok.kind  = TK_DIGIT;
        w_tok.value = i_value;
        unique case (i_kind)
            TK_DIGIT: begin
                w_keep     = 1'b1;
                w_tok.kind = TK_DIGIT;
            end
            TK_OP: begin
                w_keep     = (i_value <= OP_MAX);
                w_tok.kind = TK_OP;
            end
            TK_LPAREN: begin
                w_keep     = 1'b1;
                w_tok.kind = TK_LPAREN;
            end
            TK_RPAREN: begin
                w_keep     = 1'b1;
                w_tok.kind = TK_RPAREN;
            end
            TK_END: begin
                w_keep     = 1'b1;
                w_tok.kind = TK_END;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_tready    = !r_valid || i_tok_ready;
    assign o_tok_valid = r_valid;
    assign o_tok       = r_tok;

    // output stage toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid && w_keep;
        end
        if (o_tready) begin
            r_tok <= w_tok;
        end
    end

endmodule

`default_nettype wire

// ===== src/itp_queue.sv =====
// ----------------------------------------------------------------------------
// itp_queue
// Short token queue that decouples the classifier from the stack engine.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_queue
    import itp_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_token i_tok,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_token      o_tok
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_token        r_mem [DEPTH];
    logic [IW-1:0] r_wr_ptr;
    logic [IW-1:0] r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/itp_back.sv =====
// ----------------------------------------------------------------------------
// itp_back
// Stack engine: runs the shunting-yard steps for one token at a time on an
// operator stack memory and sends results through a hold and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_back
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_tok_valid,
    output logic        o_tok_ready,
    input  wire t_token i_tok,
    output logic        o_res_valid,
    output t_result     o_res,
    input  wire logic   i_res_ready
);

    localparam int IW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_EVAL,
        S_FLUSH
    } t_state;

    t_state              r_state, n_state;
    t_token              r_tok;
    logic [CW-1:0]       r_count, n_count;
    logic [PEND_W-1:0]   r_pending, n_pending;
    t_result             r_hold, n_hold;
    logic                r_hold_valid, n_hold_valid;
    t_result             r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic [ENTRY_W-1:0]  r_mem [STACK_DEPTH];
    logic [ENTRY_W-1:0]  r_rd_data;
    logic [CW-1:0]       w_count_m1;
    logic                w_we;
    logic [ENTRY_W-1:0]  w_wdata;

    logic                w_out_free;
    logic                w_empty;
    logic                w_top_op;
    logic                e_valid;
    logic                e_final;
    logic                e_pop;
    t_result             e_res;

    assign w_count_m1  = r_count - CW'(1);
    assign w_out_free  = !r_out_valid || i_res_ready;
    assign w_empty     = (r_count == '0);
    assign w_top_op    = !w_empty && (r_rd_data != PAREN_MARK);
    assign o_tok_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // operator stack memory, top entry read every cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[IW-1:0]] <= w_wdata;
        end
        r_rd_data <= r_mem[w_count_m1[IW-1:0]];
    end

    // step decision for the current token
    always_comb begin
        e_valid   = 1'b0;
        e_final   = 1'b0;
        e_pop     = 1'b0;
        e_res     = '{kind: OK_END, value: '0, last: 1'b0, err: ERR_NONE};
        w_we      = 1'b0;
        w_wdata   = PAREN_MARK;
        n_count   = r_count;
        n_pending = r_pending;
        n_state   = r_state;

        unique case (r_state)
            S_IDLE: begin
                if (i_tok_valid) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_out_free) begin
                    unique case (r_tok.kind)
                        TK_DIGIT: begin
                            if (r_pending < PENDING_MAX) begin
                                n_pending = r_pending + 1'b1;
                            end
                            e_valid = 1'b1;
                            e_final = 1'b1;
                            e_res.kind  = OK_OPERAND;
                            e_res.value = r_tok.value;
                        end
                        TK_OP: begin
                            if (w_top_op && (priority_of(r_rd_data) >=
                                    priority_of(r_tok.value[ENTRY_W-1:0]))) begin
                                e_pop = 1'b1;
                            end else if (r_count == FULL_CNT) begin
                                e_valid = 1'b1;
                                e_final = 1'b1;
                                e_res.err = ERR_OVERFLOW;
                            end else begin
                                w_we    = 1'b1;
                                w_wdata = r_tok.value[ENTRY_W-1:0];
                                n_count = r_count + 1'b1;
                                n_state = S_FLUSH;
                            end
                        end
                        TK_LPAREN: begin
                            if (r_count == FULL_CNT) begin
                                e_valid = 1'b1;
                                e_final = 1'b1;
                                e_res.err = ERR_OVERFLOW;
                            end else begin
                                w_we    = 1'b1;
                                w_wdata = PAREN_MARK;
                                n_count = r_count + 1'b1;
                                n_state = S_FLUSH;
                            end
                        end
                        TK_RPAREN: begin
                            if (w_top_op) begin
                                e_pop = 1'b1;
                            end else if (w_empty) begin
                                e_valid = 1'b1;
                                e_final = 1'b1;
                                e_res.err = ERR_PAREN;
                            end else begin
                                n_count = w_count_m1;
                                n_state = S_FLUSH;
                            end
                        end
                        TK_END: begin
                            if (w_top_op) begin
                                e_pop = 1'b1;
                            end else if (!w_empty) begin
                                e_valid = 1'b1;
                                e_final = 1'b1;
                                e_res.err = ERR_PAREN;
                            end else begin
                                e_valid = 1'b1;
                                e_final = 1'b1;
                                e_res.err = (r_pending != 5'd1) ? ERR_OPERAND : ERR_NONE;
                            end
                        end
                        default: begin
                            n_state = S_FLUSH;
                        end
                    endcase

                    // pop one operator, or fail for lack of operands
                    if (e_pop) begin
                        e_valid = 1'b1;
                        if (r_pending < 5'd2) begin
                            e_final   = 1'b1;
                            e_res.err = ERR_OPERAND;
                        end else begin
                            e_res.kind  = OK_OPERATOR;
                            e_res.value = VALUE_W'(r_rd_data);
                            n_pending   = r_pending - 1'b1;
                            n_count     = w_count_m1;
                        end
                    end

                    // end markers and errors drop the expression
                    if (e_valid && e_final && (e_res.kind == OK_END)) begin
                        n_count   = '0;
                        n_pending = '0;
                    end

                    if (e_valid) begin
                        n_state = e_final ? S_FLUSH : S_WAIT;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_hold_valid || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold and output stages
    always_comb begin
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_res_ready;
        if (e_valid) begin
            if (r_hold_valid) begin
                n_out       = r_hold;
                n_out.last  = 1'b0;
                n_out_valid = 1'b1;
            end
            n_hold       = e_res;
            n_hold_valid = 1'b1;
        end else if ((r_state == S_FLUSH) && r_hold_valid && w_out_free) begin
            n_out        = r_hold;
            n_out.last   = 1'b1;
            n_out_valid  = 1'b1;
            n_hold_valid = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_pending    <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pending    <= n_pending;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
        r_hold <= n_hold;
        r_out  <= n_out;
        if ((r_state == S_IDLE) && i_tok_valid) begin
            r_tok <= i_tok;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/postfix_order_checker.sv =====
// ----------------------------------------------------------------------------
// postfix_order_checker
// Watches the token and result streams of the converter. Every accepted
// token is run through a shunting-yard predictor that keeps its own operator
// stack and operand count, and the predicted postfix results are compared
// field by field with the results the block hands out.
// ----------------------------------------------------------------------------
module postfix_order_checker
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [7:0]         i_s_tdata,   // [3:0] token_value, [7:4] zero
    input  logic [KIND_W-1:0]  i_s_tuser,   // [2:0] token_kind
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [7:0]         i_m_tdata,   // [3:0] out_value, [5:4] error
    input  logic [OKIND_W-1:0] i_m_tuser,   // [1:0] out_kind
    input  logic               i_m_tlast,
    output int                 o_fail_count,
    output int                 o_open_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    // predictor state
    logic [ENTRY_W-1:0] op_stack [STACK_DEPTH];
    int unsigned        depth_used = 0;
    int unsigned        operands   = 0;

    // results of the token in progress are held back one place so the
    // final one can get its last flag
    t_result held;
    bit      have_held;
    t_result postfix_q[$];

    function automatic int rank(input logic [ENTRY_W-1:0] code);
        if (code < 3'd2) return 1;
        if (code < 3'd4) return 2;
        return 0;
    endfunction

    function automatic void put(input t_out_kind k, input logic [VALUE_W-1:0] v,
                                input t_err e);
        if (have_held) postfix_q = {postfix_q, held};
        held.kind  = k;
        held.value = v;
        held.last  = 1'b0;
        held.err   = e;
        have_held  = 1'b1;
    endfunction

    // error result, expression dropped
    function automatic void abandon_expr(input t_err e);
        put(OK_END, '0, e);
        depth_used = 0;
        operands   = 0;
    endfunction

    // emit the top operator; returns 1 when operands run short
    function automatic bit pop_op();
        if (operands < 2) begin
            abandon_expr(ERR_OPERAND);
            return 1'b1;
        end
        operands = operands - 1;
        put(OK_OPERATOR, {1'b0, op_stack[depth_used-1]}, ERR_NONE);
        depth_used = depth_used - 1;
        return 1'b0;
    endfunction

    function automatic void push_entry(input logic [ENTRY_W-1:0] code);
        if (depth_used >= STACK_DEPTH) begin
            abandon_expr(ERR_OVERFLOW);
        end else begin
            op_stack[depth_used] = code;
            depth_used = depth_used + 1;
        end
    endfunction

    function automatic void predict_token(input logic [KIND_W-1:0] kind,
                                          input logic [VALUE_W-1:0] value);
        bit bad;
        bad = 1'b0;
        have_held = 1'b0;
        case (kind)
            TK_DIGIT: begin
                if (operands < PENDING_MAX) operands = operands + 1;
                put(OK_OPERAND, value, ERR_NONE);
            end
            TK_OP: begin
                // bad operator codes are dropped silently
                if (value <= OP_MAX) begin
                    while (!bad && depth_used > 0 && op_stack[depth_used-1] != PAREN_MARK &&
                           rank(op_stack[depth_used-1]) >= rank(value[ENTRY_W-1:0]))
                        bad = pop_op();
                    if (!bad) push_entry(value[ENTRY_W-1:0]);
                end
            end
            TK_LPAREN: begin
                push_entry(PAREN_MARK);
            end
            TK_RPAREN: begin
                while (!bad && depth_used > 0 && op_stack[depth_used-1] != PAREN_MARK)
                    bad = pop_op();
                if (!bad) begin
                    if (depth_used == 0) abandon_expr(ERR_PAREN);
                    else depth_used = depth_used - 1;
                end
            end
            TK_END: begin
                // flush, a left paren left on the stack is unmatched
                while (!bad && depth_used > 0) begin
                    if (op_stack[depth_used-1] == PAREN_MARK) begin
                        abandon_expr(ERR_PAREN);
                        bad = 1'b1;
                    end else begin
                        bad = pop_op();
                    end
                end
                if (!bad) begin
                    if (operands != 1) begin
                        abandon_expr(ERR_OPERAND);
                    end else begin
                        put(OK_END, '0, ERR_NONE);
                        depth_used = 0;
                        operands   = 0;
                    end
                end
            end
            default: ;
        endcase
        if (have_held) begin
            held.last = 1'b1;
            postfix_q = {postfix_q, held};
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    // results are checked before the token of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            depth_used = 0;
            operands   = 0;
            postfix_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (postfix_q.size() == 0) begin
                    $error("result kind %0d value %0d arrived with nothing expected",
                           i_m_tuser, i_m_tdata[3:0]);
                    o_fail_count++;
                end else begin
                    held = postfix_q.pop_front();
                    check_field("out_kind", held.kind, i_m_tuser);
                    check_field("out_value", held.value, i_m_tdata[3:0]);
                    check_field("last", held.last, i_m_tlast);
                    check_field("error", held.err, i_m_tdata[5:4]);
                end
            end
            if (i_s_tvalid && i_s_tready) predict_token(i_s_tuser, i_s_tdata[3:0]);
        end
        o_open_cnt = postfix_q.size();
    end

endmodule

// ===== tb/sv/infix_to_postfix_converter_tb.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb
// Feeds infix tokens to the converter: a directed set of short expressions
// and error cases, then random well-formed expressions, broken ones, noise
// and stack overflow runs, with random gaps on both streams and one long
// result hold-off. The checker next to the block judges every result.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import itp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int IDLE_PCT     = 37;
    localparam int RANDOM_ITEMS = 140;

    // operator codes
    localparam logic [VALUE_W-1:0] OP_ADD = 4'd0;
    localparam logic [VALUE_W-1:0] OP_SUB = 4'd1;
    localparam logic [VALUE_W-1:0] OP_MUL = 4'd2;
    localparam logic [VALUE_W-1:0] OP_DIV = 4'd3;
    localparam logic [VALUE_W-1:0] OP_BAD = 4'd4;
    // kinds the block does not know
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
    } t_tok;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [7:0]         s_tdata  = '0;
    logic [KIND_W-1:0]  s_tuser  = '0;
    logic               m_tready = 1'b0;
    logic               s_tready;
    logic               m_tvalid;
    logic [7:0]         m_tdata;
    logic [OKIND_W-1:0] m_tuser;
    logic               m_tlast;

    int   fail_count;
    int   open_cnt;
    int   cycle_count = 0;
    int   counted     = 0;
    int   hold_left   = 0;
    bit   calm        = 1'b0;
    bit   hold_req    = 1'b0;
    t_tok expr_q[$];

    infix_to_postfix_converter u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    postfix_order_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_open_cnt   (open_cnt)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("infix_to_postfix_converter_tb: done, errors");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic void add_tok(input logic [KIND_W-1:0] kind,
                                    input logic [VALUE_W-1:0] value);
        t_tok t;
        t.kind  = kind;
        t.value = value;
        expr_q = {expr_q, t};
    endfunction

    // parens and end carry a random value, which the block ignores
    function automatic void add_mark(input logic [KIND_W-1:0] kind);
        add_tok(kind, 4'($urandom_range(0, 15)));
    endfunction

    function automatic void gen_operand(input int nest);
        if (nest > 0 && $urandom_range(0, 3) == 0) begin
            add_mark(TK_LPAREN);
            gen_expr(nest - 1);
            add_mark(TK_RPAREN);
        end else begin
            add_tok(TK_DIGIT, 4'($urandom_range(0, 15)));
        end
    endfunction

    function automatic void gen_expr(input int nest);
        int n_ops;
        n_ops = $urandom_range(0, 4);
        gen_operand(nest);
        repeat (n_ops) begin
            add_tok(TK_OP, 4'($urandom_range(0, 3)));
            gen_operand(nest);
        end
    endfunction

    // one token, with random gaps before it
    task automatic send_tok(input t_tok t);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= t.kind;
        s_tdata  <= {4'b0, t.value};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (t.kind <= TK_END && !(t.kind == TK_OP && t.value > OP_MAX)) counted++;
    endtask

    task automatic send_expr();
        foreach (expr_q[i]) send_tok(expr_q[i]);
        expr_q.delete();
    endtask

    initial begin
        int   pick;
        int   idx;
        int   seqn;
        bit   hold_done;
        t_tok t;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed: single operand, all operators with parens and a wide digit
        add_tok(TK_DIGIT, 4'd0);
        add_mark(TK_END);
        add_tok(TK_DIGIT, 4'd15);
        add_tok(TK_OP, OP_ADD);
        add_tok(TK_DIGIT, 4'd9);
        add_tok(TK_OP, OP_MUL);
        add_mark(TK_LPAREN);
        add_tok(TK_DIGIT, 4'd3);
        add_tok(TK_OP, OP_SUB);
        add_tok(TK_DIGIT, 4'd2);
        add_mark(TK_RPAREN);
        add_tok(TK_OP, OP_DIV);
        add_tok(TK_DIGIT, 4'd7);
        add_mark(TK_END);
        // ignored tokens: bad operator code, unused kinds
        add_tok(TK_OP, 4'd15);
        add_tok(TK_OP, OP_BAD);
        add_tok(KIND_SPARE_LO, 4'd0);
        add_tok(KIND_SPARE_HI, 4'd15);
        // empty expression, adjacent operands
        add_mark(TK_END);
        add_tok(TK_DIGIT, 4'd1);
        add_tok(TK_DIGIT, 4'd2);
        add_mark(TK_END);
        // missing operand, lone right paren, unclosed left paren
        add_tok(TK_OP, OP_ADD);
        add_tok(TK_OP, OP_SUB);
        add_mark(TK_RPAREN);
        add_mark(TK_LPAREN);
        add_tok(TK_DIGIT, 4'd5);
        add_mark(TK_END);
        send_expr();

        // random expressions
        counted   = 0;
        seqn      = 0;
        hold_done = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            calm = (counted >= 50 && counted < 90);
            if (!hold_done && counted >= 110) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            pick = (seqn == 0) ? 92 : $urandom_range(0, 99);
            if (pick < 65) begin
                gen_expr(3);
                add_mark(TK_END);
            end else if (pick < 80) begin
                // broken expression
                gen_expr(2);
                idx = $urandom_range(0, expr_q.size() - 1);
                case ($urandom_range(0, 2))
                    0: expr_q.delete(idx);
                    1: begin
                        t.kind  = 3'($urandom_range(0, 3));
                        t.value = 4'($urandom_range(0, 15));
                        expr_q[idx] = t;
                    end
                    default: begin
                        t.kind  = $urandom_range(0, 1) ? TK_LPAREN : TK_RPAREN;
                        t.value = 4'($urandom_range(0, 15));
                        expr_q.insert(idx, t);
                    end
                endcase
                add_mark(TK_END);
            end else if (pick < 90) begin
                // noise over the whole token space
                repeat ($urandom_range(1, 6))
                    add_tok(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
                if ($urandom_range(0, 1)) add_mark(TK_END);
            end else if (pick < 95) begin
                // paren run around the stack depth
                repeat ($urandom_range(DEF_STACK_DEPTH - 2, DEF_STACK_DEPTH + 2))
                    add_mark(TK_LPAREN);
                add_tok(TK_DIGIT, 4'($urandom_range(0, 15)));
                add_mark(TK_END);
            end else begin
                add_mark(TK_END);
            end
            send_expr();
            seqn++;
        end
        calm = 1'b0;

        // drain
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (open_cnt != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("infix_to_postfix_converter_tb: done, clean");
        end else begin
            $display("infix_to_postfix_converter_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/itp_pkg.sv
src/itp_front.sv
src/itp_queue.sv
src/itp_back.sv
src/infix_to_postfix_converter.sv
tb/sv/postfix_order_checker.sv
tb/sv/infix_to_postfix_converter_tb.sv
